@@ design/sktd_pkg.sv @@
// ----------------------------------------------------------------------------
// sktd_pkg: shared types and constants for the sorted key table
// Field widths, action and status codes, and the command/status bundles that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
package sktd_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_BYTES_DEF   = 7;

  localparam int KEY_W      = 56;
  localparam int DATE_W     = 23;  // {year[13:0], month[3:0], day[4:0]}
  localparam int CNT_OUT_W  = 5;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 96;

  // input beat layout
  localparam int I_ACT_LSB   = 0;
  localparam int I_KEY_LSB   = 2;
  localparam int I_DAY_LSB   = 58;
  localparam int I_MONTH_LSB = 63;
  localparam int I_YEAR_LSB  = 67;

  // output beat layout
  localparam int O_STATUS_LSB = 0;
  localparam int O_KEY_LSB    = 2;
  localparam int O_DATE_LSB   = 58;
  localparam int O_CNT_LSB    = 81;
  localparam int O_REM_LSB    = 86;
  localparam int O_USED_W     = 91;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_PURGE  = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;
  localparam logic [1:0] ACT_DUMP   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_READ,
    SRC_PEND
  } out_src_t;

  typedef enum logic {
    WR_READ,
    WR_NEW
  } wr_src_t;

  typedef struct packed {
    logic       load_in;
    logic       rd_en;
    logic       wr_en;
    wr_src_t    wr_src;
    logic       lat_date;
    logic       pend_load;
    logic       out_load;
    out_src_t   out_src;
    logic [1:0] out_status;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic key_ge;
    logic date_eq;
    logic out_free;
  } stat_t;

endpackage

@@ design/sktd_dp.sv @@
// ----------------------------------------------------------------------------
// sktd_dp: table datapath
// Entry memory (one write port, one registered read port), held new entry,
// held compare date, pending report entry, comparators and the output stage.
// ----------------------------------------------------------------------------
module sktd_dp import sktd_pkg::*; #(
  parameter int  TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int  KEY_BYTES   = KEY_BYTES_DEF,
  localparam int IdxW        = $clog2(TABLE_DEPTH),
  localparam int CntW        = $clog2(TABLE_DEPTH + 1),
  localparam int KeyW        = 8 * KEY_BYTES,
  localparam int EntW        = KeyW + DATE_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic [IdxW-1:0]        raddr,
  input  logic [IdxW-1:0]        waddr,
  input  logic [CntW-1:0]        cnt,
  input  logic [CntW-1:0]        removed,
  input  logic [KEY_W-1:0]       in_key,
  input  logic [DATE_W-1:0]      in_date,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  logic [EntW-1:0]      mem [TABLE_DEPTH];
  logic [EntW-1:0]      rd_q;
  logic [EntW-1:0]      new_ent;
  logic [EntW-1:0]      pend;
  logic [DATE_W-1:0]    date_i;
  logic [EntW-1:0]      wdata;
  logic [EntW-1:0]      sel_ent;
  logic [63:0]          key_ext;
  logic [63:0]          out_key_ext;

  logic [1:0]           o_status;
  logic [KEY_W-1:0]     o_key;
  logic [DATE_W-1:0]    o_date;
  logic [CNT_OUT_W-1:0] o_count;
  logic [CNT_OUT_W-1:0] o_removed;

  assign key_ext = 64'(in_key);
  assign wdata   = (cmd.wr_src == WR_NEW) ? new_ent : rd_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[raddr];
    end
    if (cmd.load_in) begin
      new_ent <= {key_ext[KeyW-1:0], in_date};
    end
    if (cmd.lat_date) begin
      date_i <= rd_q[DATE_W-1:0];
    end
    if (cmd.pend_load) begin
      pend <= rd_q;
    end
  end

  assign stat.key_ge   = rd_q[EntW-1 -: KeyW] >= new_ent[EntW-1 -: KeyW];
  assign stat.date_eq  = rd_q[DATE_W-1:0] == date_i;
  assign stat.out_free = !m_tvalid || m_tready;

  always_comb begin
    case (cmd.out_src)
      SRC_READ: sel_ent = rd_q;
      SRC_PEND: sel_ent = pend;
      default:  sel_ent = '0;
    endcase
  end

  assign out_key_ext = 64'(sel_ent[EntW-1 -: KeyW]);

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.out_load) begin
      o_status  <= cmd.out_status;
      o_key     <= out_key_ext[KEY_W-1:0];
      o_date    <= sel_ent[DATE_W-1:0];
      o_count   <= CNT_OUT_W'(cnt);
      o_removed <= CNT_OUT_W'(removed);
      m_tlast   <= cmd.out_last;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - O_USED_W)'(0), o_removed, o_count, o_date, o_key, o_status};

endmodule

@@ design/sktd_ctrl.sv @@
// ----------------------------------------------------------------------------
// sktd_ctrl: table controller
// Sequences insert (shift from the top), pairwise date scans for purge and
// report, purge compaction and dump; tracks fill count and drop flags.
// ----------------------------------------------------------------------------
module sktd_ctrl import sktd_pkg::*; #(
  parameter int  TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int IdxW        = $clog2(TABLE_DEPTH),
  localparam int CntW        = $clog2(TABLE_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [1:0]      action,
  input  stat_t           stat,
  output cmd_t            cmd,
  output logic [IdxW-1:0] raddr,
  output logic [IdxW-1:0] waddr,
  output logic [CntW-1:0] cnt,
  output logic [CntW-1:0] removed
);

  typedef enum logic [2:0] {
    IDLE,
    INS_CMP,
    INS_PUT,
    SC_LATI,
    SC_CMP,
    CP_WR,
    DUMP,
    EMIT
  } state_t;

  state_t                 state, state_next;
  logic [CntW-1:0]        cnt_next, removed_next;
  logic [CntW-1:0]        i, i_next, j, j_next, w, w_next;
  logic [TABLE_DEPTH-1:0] drop, drop_next;
  logic                   is_rep, is_rep_next;
  logic                   pend, pend_next;
  logic                   emit_pend, emit_pend_next;
  logic [1:0]             emit_status, emit_status_next;

  logic [CntW:0]          i1, i2, j1, cnt_x;
  logic [CntW-1:0]        im1, cnt_m1, w_add;
  logic                   keep;
  logic                   adv;

  assign i1     = (CntW + 1)'(i) + (CntW + 1)'(1);
  assign i2     = (CntW + 1)'(i) + (CntW + 1)'(2);
  assign j1     = (CntW + 1)'(j) + (CntW + 1)'(1);
  assign cnt_x  = (CntW + 1)'(cnt);
  assign im1    = i - CntW'(1);
  assign cnt_m1 = cnt - CntW'(1);
  assign keep   = !drop[i[IdxW-1:0]];
  assign w_add  = w + CntW'(keep);

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    removed_next     = removed;
    i_next           = i;
    j_next           = j;
    w_next           = w;
    drop_next        = drop;
    is_rep_next      = is_rep;
    pend_next        = pend;
    emit_pend_next   = emit_pend;
    emit_status_next = emit_status;
    cmd              = '0;
    raddr            = '0;
    waddr            = '0;
    adv              = 1'b0;
    s_tready         = (state == IDLE);

    case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load_in      = 1'b1;
          removed_next     = '0;
          pend_next        = 1'b0;
          emit_pend_next   = 1'b0;
          emit_status_next = ST_OK;
          i_next           = '0;
          case (action)
            ACT_INSERT: begin
              if (cnt == CntW'(TABLE_DEPTH)) begin
                emit_status_next = ST_FULL;
                state_next       = EMIT;
              end else if (cnt == '0) begin
                state_next = INS_PUT;
              end else begin
                cmd.rd_en  = 1'b1;
                raddr      = cnt_m1[IdxW-1:0];
                i_next     = cnt_m1;
                state_next = INS_CMP;
              end
            end
            ACT_PURGE, ACT_REPORT: begin
              is_rep_next = (action == ACT_REPORT);
              drop_next   = '0;
              if (cnt < CntW'(2)) begin
                emit_status_next = (action == ACT_REPORT) ? ST_NONE : ST_OK;
                state_next       = EMIT;
              end else begin
                cmd.rd_en  = 1'b1;
                state_next = SC_LATI;
              end
            end
            default: begin
              if (cnt == '0) begin
                emit_status_next = ST_NONE;
                state_next       = EMIT;
              end else begin
                cmd.rd_en  = 1'b1;
                state_next = DUMP;
              end
            end
          endcase
        end
      end

      // walk down from the top, moving keys that are not smaller up one slot
      INS_CMP: begin
        cmd.wr_en = 1'b1;
        waddr     = i1[IdxW-1:0];
        if (stat.key_ge) begin
          cmd.wr_src = WR_READ;
          if (i == '0) begin
            state_next = INS_PUT;
          end else begin
            cmd.rd_en = 1'b1;
            raddr     = im1[IdxW-1:0];
            i_next    = im1;
          end
        end else begin
          cmd.wr_src = WR_NEW;
          cnt_next   = cnt + CntW'(1);
          state_next = EMIT;
        end
      end

      INS_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_NEW;
        waddr      = i[IdxW-1:0];
        cnt_next   = cnt + CntW'(1);
        state_next = EMIT;
      end

      SC_LATI: begin
        cmd.lat_date = 1'b1;
        cmd.rd_en    = 1'b1;
        raddr        = i1[IdxW-1:0];
        j_next       = i1[CntW-1:0];
        state_next   = SC_CMP;
      end

      SC_CMP: begin
        if (stat.date_eq) begin
          if (is_rep) begin
            // hold the previous match until the output stage frees up
            if (!pend || stat.out_free) begin
              cmd.out_load   = pend;
              cmd.out_src    = SRC_PEND;
              cmd.out_status = ST_OK;
              cmd.out_last   = 1'b0;
              cmd.pend_load  = 1'b1;
              pend_next      = 1'b1;
              adv            = 1'b1;
            end
          end else begin
            drop_next[i[IdxW-1:0]] = 1'b1;
            adv                    = 1'b1;
          end
        end else if (j1 < cnt_x) begin
          cmd.rd_en = 1'b1;
          raddr     = j1[IdxW-1:0];
          j_next    = j1[CntW-1:0];
        end else begin
          adv = 1'b1;
        end

        if (adv) begin
          if (i2 < cnt_x) begin
            cmd.rd_en  = 1'b1;
            raddr      = i1[IdxW-1:0];
            i_next     = i1[CntW-1:0];
            state_next = SC_LATI;
          end else if (is_rep) begin
            emit_pend_next   = pend_next;
            emit_status_next = pend_next ? ST_OK : ST_NONE;
            state_next       = EMIT;
          end else begin
            cmd.rd_en  = 1'b1;
            raddr      = '0;
            i_next     = '0;
            w_next     = '0;
            state_next = CP_WR;
          end
        end
      end

      // compaction: survivors slide down to the write pointer
      CP_WR: begin
        cmd.wr_en  = keep;
        cmd.wr_src = WR_READ;
        waddr      = w[IdxW-1:0];
        if (i1 < cnt_x) begin
          cmd.rd_en = 1'b1;
          raddr     = i1[IdxW-1:0];
          i_next    = i1[CntW-1:0];
          w_next    = w_add;
        end else begin
          cnt_next     = w_add;
          removed_next = cnt - w_add;
          state_next   = EMIT;
        end
      end

      DUMP: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = SRC_READ;
          cmd.out_status = ST_OK;
          cmd.out_last   = (i1 == cnt_x);
          if (i1 < cnt_x) begin
            cmd.rd_en = 1'b1;
            raddr     = i1[IdxW-1:0];
            i_next    = i1[CntW-1:0];
          end else begin
            state_next = IDLE;
          end
        end
      end

      EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = emit_pend ? SRC_PEND : SRC_ZERO;
          cmd.out_status = emit_status;
          cmd.out_last   = 1'b1;
          state_next     = IDLE;
        end
      end

      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      cnt         <= '0;
      removed     <= '0;
      i           <= '0;
      j           <= '0;
      w           <= '0;
      drop        <= '0;
      is_rep      <= 1'b0;
      pend        <= 1'b0;
      emit_pend   <= 1'b0;
      emit_status <= ST_OK;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      removed     <= removed_next;
      i           <= i_next;
      j           <= j_next;
      w           <= w_next;
      drop        <= drop_next;
      is_rep      <= is_rep_next;
      pend        <= pend_next;
      emit_pend   <= emit_pend_next;
      emit_status <= emit_status_next;
    end
  end

endmodule

@@ design/sorted_key_table_with_date_dedupe.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_with_date_dedupe: sorted key table with shared-date purge
// Holds up to TABLE_DEPTH {key, date} entries in ascending key order and
// serves insert, purge, report and dump commands over stream ports.
// ----------------------------------------------------------------------------
// One command is taken at a time; s_tready is high only while the block is
// idle, and a finished result may still sit in the output stage while the next
// command is taken. All entries live in one memory with a single registered
// read port. Report compares each entry with the later ones until a date
// match, with one memory read per cycle while the output stage does not stall;
// purge adds a compaction pass to that. Back-pressure on the result side adds
// stalls to any command. No clearing pass follows reset.
module sorted_key_table_with_date_dedupe import sktd_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // action[1:0], key[57:2], day[62:58], month[66:63], year[80:67], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status[1:0], entry_key[57:2], entry_day[62:58], entry_month[66:63],
  // entry_year[80:67], entry_count[85:81], removed_count[90:86], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  cmd_t               cmd;
  stat_t              stat;
  logic [IdxW-1:0]    raddr, waddr;
  logic [CntW-1:0]    cnt, removed;
  logic [1:0]         action;
  logic [KEY_W-1:0]   in_key;
  logic [DATE_W-1:0]  in_date;

  assign action  = s_tdata[I_ACT_LSB +: 2];
  assign in_key  = s_tdata[I_KEY_LSB +: KEY_W];
  assign in_date = {s_tdata[I_YEAR_LSB +: 14], s_tdata[I_MONTH_LSB +: 4],
                    s_tdata[I_DAY_LSB +: 5]};

  sktd_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd),
    .raddr    (raddr),
    .waddr    (waddr),
    .cnt      (cnt),
    .removed  (removed)
  );

  sktd_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .raddr    (raddr),
    .waddr    (waddr),
    .cnt      (cnt),
    .removed  (removed),
    .in_key   (in_key),
    .in_date  (in_date),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ design/sktd_chk.sv @@
// ----------------------------------------------------------------------------
// sktd_chk: port-level checks for the sorted key table
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module sktd_chk import sktd_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tlast
);

  logic [1:0]           o_status;
  logic [CNT_OUT_W-1:0] o_count;
  logic [CNT_OUT_W-1:0] o_removed;
  logic [KEY_W-1:0]     o_key;

  assign o_status  = m_tdata[O_STATUS_LSB +: 2];
  assign o_count   = m_tdata[O_CNT_LSB +: CNT_OUT_W];
  assign o_removed = m_tdata[O_REM_LSB +: CNT_OUT_W];
  assign o_key     = m_tdata[O_KEY_LSB +: KEY_W];

  default disable iff (rst);

  a_out_hold: assert property (@(posedge clk)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // a non-final beat means the command is still running
  a_busy_mid_run: assert property (@(posedge clk)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("command taken in the middle of a result run");

  a_full_count: assert property (@(posedge clk)
    m_tvalid && o_status == ST_FULL |-> m_tlast && o_count == CNT_OUT_W'(TABLE_DEPTH))
    else $error("table full reported with a short count");

  a_removed_only_purge: assert property (@(posedge clk)
    m_tvalid && o_removed != '0 |-> m_tlast && o_status == ST_OK && o_key == '0)
    else $error("removed count on a non-purge beat");

endmodule

bind sorted_key_table_with_date_dedupe sktd_chk #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_sktd_chk (.*);
